// File: hw/rtl/smce_pkg.sv
// ----------------------------------------------------------------------------
// smce_pkg
// Shared types and constants of the softmax cross-entropy loss engine.
// ----------------------------------------------------------------------------
package smce_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
	localparam logic [1:0] REG_BATCH_ROWS  = 2'd1;
	localparam logic [1:0] REG_GRAD_ENABLE = 2'd2;
	localparam logic [1:0] REG_UPSTREAM    = 2'd3;

	// Result kinds
	localparam logic KIND_GRAD = 1'b0;
	localparam logic KIND_LOSS = 1'b1;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	// Request to the serial divider: start pulse and dividend width in bits
	typedef struct packed {
		logic       start;
		logic [6:0] nbits;
	} div_req_t;

endpackage

// File: hw/rtl/smce_mul.sv
// ----------------------------------------------------------------------------
// smce_mul
// Shared signed 33x33 multiplier, product registered.
// ----------------------------------------------------------------------------
module smce_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

// File: hw/rtl/smce_div.sv
// ----------------------------------------------------------------------------
// smce_div
// Shared restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module smce_div (
	input  logic                clk,
	input  logic                arst_n,
	input  smce_pkg::div_req_t  req,
	input  logic [63:0]         dividend,
	input  logic [31:0]         divisor,
	output logic                done_q,
	output logic [63:0]         quo_q
);
	import smce_pkg::*;

	logic        run_q;
	logic [6:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] sh;
	logic        ge;

	assign sh = {rem_q, quo_q[63]};
	assign ge = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// left-align the dividend so each step takes the top bit
			quo_q <= dividend << (7'd64 - req.nbits);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? 32'(sh - {1'b0, dvs_q}) : sh[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end
endmodule

// File: hw/rtl/softmax_cross_entropy_loss_top.sv
// ----------------------------------------------------------------------------
// softmax_cross_entropy_loss_top
// Streaming softmax cross-entropy loss with per-class gradients.
// ----------------------------------------------------------------------------
// A logit that does not close a row is taken and busy stays low.
// The logit that closes a row starts the row sequence, during which busy is
// high: a row maximum pass, e^-1 and then e^-x for each class by a series
// up to the 16th-order term, one probability division per class, a 20-step
// log, and gradient divisions. All products and quotients come from one shared
// multiplier and one serial divider that yields one quotient bit per cycle; the
// divider sets the length. For each class, e^-x takes one power step for each
// whole unit (1.0 in Q8.8) that its logit lies below the row maximum, at most
// 31 per class. A class lying 32 or more below the maximum skips its series
// and power steps. Gradients off skip the gradient divisions, and a row
// without the mean loss skips the loss division.
// Results appear on value/kind/class_index/last for exactly one cycle with
// valid high; the receiver cannot stall them, so it must take every beat.
module softmax_cross_entropy_loss_top #(
	parameter int CLASSES    = 16,
	parameter int LOGIT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_addr,
	input  logic [31:0]                  cfg_wdata,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [LOGIT_BITS-1:0] logit,
	input  logic [3:0]                   label,
	output logic                         valid,
	output logic                         kind,
	output logic signed [31:0]           value,
	output logic [3:0]                   class_index,
	output logic                         last
);
	import smce_pkg::*;

	localparam int IW = (CLASSES > 2) ? $clog2(CLASSES) : 1;
	localparam int CW = $clog2(CLASSES + 1);
	localparam int XW = LOGIT_BITS + 1;
	localparam int LW = (CW > 4) ? CW : 4;

	typedef enum logic [24:0] {
		S_IDLE   = 25'd1 << 0,
		S_MAXRD  = 25'd1 << 1,
		S_MAX    = 25'd1 << 2,
		S_SMUL   = 25'd1 << 3,
		S_SMULW  = 25'd1 << 4,
		S_SDIV   = 25'd1 << 5,
		S_EXPRD  = 25'd1 << 6,
		S_EXPX   = 25'd1 << 7,
		S_POW    = 25'd1 << 8,
		S_POWW   = 25'd1 << 9,
		S_EXPST  = 25'd1 << 10,
		S_PRD    = 25'd1 << 11,
		S_PDIV0  = 25'd1 << 12,
		S_PDIV   = 25'd1 << 13,
		S_LOGI   = 25'd1 << 14,
		S_LMUL   = 25'd1 << 15,
		S_LMULW  = 25'd1 << 16,
		S_LN     = 25'd1 << 17,
		S_LNW    = 25'd1 << 18,
		S_GRD    = 25'd1 << 19,
		S_GMUL   = 25'd1 << 20,
		S_GMULW  = 25'd1 << 21,
		S_GDIV   = 25'd1 << 22,
		S_ROWEND = 25'd1 << 23,
		S_LDIV   = 25'd1 << 24
	} state_t;

	// configuration
	logic [4:0]         class_count_q;
	logic [15:0]        batch_rows_q;
	logic               grad_enable_q;
	logic signed [31:0] upstream_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= 5'd16;
			batch_rows_q  <= 16'd1;
			grad_enable_q <= 1'b1;
			upstream_q    <= 32'sd65536;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CLASS_COUNT: class_count_q <= cfg_wdata[4:0];
				REG_BATCH_ROWS:  batch_rows_q  <= cfg_wdata[15:0];
				REG_GRAD_ENABLE: grad_enable_q <= cfg_wdata[0];
				REG_UPSTREAM:    upstream_q    <= cfg_wdata;
				default:         class_count_q <= class_count_q;
			endcase
		end
	end

	logic [CW-1:0] c_eff;
	logic [15:0]   batch;
	logic [6:0]    cc7;

	assign cc7   = {2'b00, class_count_q};
	assign c_eff = (cc7 < 7'd2) ? CW'(2) :
	               (cc7 > 7'(CLASSES)) ? CW'(CLASSES) : CW'(cc7);
	assign batch = (batch_rows_q == 16'd0) ? 16'd1 : batch_rows_q;

	// state
	state_t              state_q;
	logic [CW-1:0]       ec_q;
	logic [3:0]          row_label_q;
	logic [IW-1:0]       lab_q;
	logic [IW-1:0]       j_q;
	logic                emit_loss_q;
	logic [15:0]         row_count_q;
	logic [47:0]         loss_sum_q;
	logic signed [XW-1:0] max_q;
	logic [31:0]         exp_sum_q;
	logic [30:0]         y_q;
	logic [30:0]         term_q;
	logic signed [33:0]  sum_q;
	logic [4:0]          k_q;
	logic                ser_e1_q;
	logic [30:0]         e1_q;
	logic [30:0]         r_q;
	logic [4:0]          n_q;
	logic [24:0]         ex_q;
	logic [24:0]         plab_q;
	logic [31:0]         z_q;
	logic [19:0]         frac_q;
	logic [4:0]          m_q;
	logic [4:0]          li_q;
	logic                gneg_q;

	// memories
	logic signed [LOGIT_BITS-1:0] logit_mem [CLASSES];
	logic [24:0]                  ex_mem [CLASSES];
	logic signed [LOGIT_BITS-1:0] rd_logit_q;
	logic [24:0]                  rd_ex_q;

	// shared units
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p_q;
	div_req_t           dreq;
	logic [63:0]        dvd;
	logic [31:0]        dvs;
	logic               div_done;
	logic [63:0]        div_q;

	smce_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_p_q));

	smce_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .dividend(dvd), .divisor(dvs),
		.done_q(div_done), .quo_q(div_q)
	);

	logic accept;
	logic [CW-1:0] ec_next;
	logic          closing;
	logic [3:0]    lbl;
	logic          j_end;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign ec_next = ec_q + CW'(1);
	assign closing = ec_next >= c_eff;
	assign lbl     = (ec_q == '0) ? label : row_label_q;
	assign j_end   = (CW'(j_q) == c_eff - CW'(1));

	// combinational helpers
	logic signed [XW-1:0] xd;
	logic [XW-1:0]        xu;
	logic [XW-1:0]        nbig;
	logic [24:0]          pl;
	logic [4:0]           lead;
	logic [31:0]          zz;
	logic [24:0]          lg;
	logic [24:0]          l2;
	logic signed [25:0]   gd;
	logic [65:0]          gmag;
	logic                 sub_lab;

	assign xd   = max_q - XW'(rd_logit_q);
	assign xu   = xd;
	assign nbig = xu >> 8;
	assign pl   = (plab_q == '0) ? 25'd1 : plab_q;
	assign zz   = mul_p_q[61:30];
	assign lg   = {m_q, frac_q};
	assign l2   = (lg > 25'(24 << 20)) ? 25'd0 : 25'(24 << 20) - lg;
	assign sub_lab = (j_q == lab_q);
	assign gd   = $signed({1'b0, rd_ex_q}) - (sub_lab ? 26'sd16777216 : 26'sd0);
	assign gmag = mul_p_q[65] ? 66'(-mul_p_q) : 66'(mul_p_q);

	always_comb begin
		lead = '0;
		for (int b = 0; b < 25; b++) begin
			if (pl[b]) lead = 5'(b);
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SMUL: begin
				mul_a = {2'b00, term_q};
				mul_b = {2'b00, y_q};
			end
			S_POW: begin
				mul_a = {2'b00, r_q};
				mul_b = {2'b00, e1_q};
			end
			S_LMUL: begin
				mul_a = {1'b0, z_q};
				mul_b = {1'b0, z_q};
			end
			S_LN: begin
				mul_a = {8'b0, l2};
				mul_b = {3'b0, LN2_Q30};
			end
			S_GMUL: begin
				mul_a = {upstream_q[31], upstream_q};
				mul_b = 33'(gd);
			end
			default: mul_a = '0;
		endcase
	end

	always_comb begin
		dreq = '0;
		dvd  = '0;
		dvs  = 32'd1;
		case (state_q)
			S_SMULW: begin
				dreq = '{start: 1'b1, nbits: 7'd31};
				dvd  = {33'b0, mul_p_q[60:30]};
				dvs  = {27'b0, k_q};
			end
			S_PDIV0: begin
				dreq = '{start: 1'b1, nbits: 7'd49};
				dvd  = {15'b0, rd_ex_q, 24'b0};
				dvs  = exp_sum_q;
			end
			S_GMULW: begin
				dreq = '{start: 1'b1, nbits: 7'd34};
				dvd  = {30'b0, gmag[57:24]};
				dvs  = {16'b0, batch};
			end
			S_ROWEND: begin
				dreq = '{start: emit_loss_q, nbits: 7'd48};
				dvd  = {16'b0, loss_sum_q};
				dvs  = {16'b0, batch};
			end
			default: dreq = '0;
		endcase
	end

	// memories: written and read in clocked blocks, read data registered
	always_ff @(posedge clk) begin
		if (accept) logit_mem[IW'(ec_q)] <= logit;
		rd_logit_q <= logit_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXPST) ex_mem[j_q] <= ex_q;
		else if (state_q == S_PDIV && div_done) ex_mem[j_q] <= div_q[24:0];
		rd_ex_q <= ex_mem[j_q];
	end

	logic [33:0] gq;
	logic [31:0] gsat;
	logic [31:0] lsat;

	assign gq   = div_q[33:0];
	assign gsat = !gneg_q ? ((gq > 34'h7FFF_FFFF) ? 32'h7FFF_FFFF : gq[31:0]) :
	              ((gq > 34'h8000_0000) ? 32'h8000_0000 : 32'(-gq[31:0]));
	assign lsat = (div_q[47:0] > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ec_q        <= '0;
			row_label_q <= '0;
			row_count_q <= '0;
			loss_sum_q  <= '0;
			exp_sum_q   <= '0;
			max_q       <= '0;
			valid       <= 1'b0;
			j_q         <= '0;
			lab_q       <= '0;
			emit_loss_q <= 1'b0;
			y_q         <= '0;
			term_q      <= '0;
			sum_q       <= '0;
			k_q         <= '0;
			ser_e1_q    <= 1'b0;
			n_q         <= '0;
			ex_q        <= '0;
			plab_q      <= '0;
			z_q         <= '0;
			frac_q      <= '0;
			m_q         <= '0;
			li_q        <= '0;
			gneg_q      <= 1'b0;
			kind        <= KIND_GRAD;
			value       <= '0;
			class_index <= '0;
			last        <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (ec_q == '0) row_label_q <= label;
						if (closing) begin
							ec_q        <= '0;
							j_q         <= '0;
							lab_q       <= (LW'(lbl) >= LW'(c_eff)) ?
							               IW'(c_eff - CW'(1)) : IW'(lbl);
							emit_loss_q <= (row_count_q + 16'd1) >= batch;
							exp_sum_q   <= '0;
							state_q     <= S_MAXRD;
						end else begin
							ec_q <= ec_next;
						end
					end
				end
				S_MAXRD: state_q <= S_MAX;
				S_MAX: begin
					if (j_q == '0 || XW'(rd_logit_q) > max_q) max_q <= XW'(rd_logit_q);
					if (j_end) begin
						j_q      <= '0;
						y_q      <= Q30_ONE;
						term_q   <= Q30_ONE;
						sum_q    <= 34'(Q30_ONE);
						k_q      <= 5'd1;
						ser_e1_q <= 1'b1;
						state_q  <= S_SMUL;
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= S_MAXRD;
					end
				end
				S_SMUL:  state_q <= S_SMULW;
				S_SMULW: state_q <= S_SDIV;
				S_SDIV: begin
					if (div_done) begin
						term_q <= div_q[30:0];
						// odd terms subtract, even terms add
						if (k_q[0]) begin
							sum_q <= sum_q - 34'(div_q[30:0]);
						end else begin
							sum_q <= sum_q + 34'(div_q[30:0]);
						end
						if (k_q == 5'd16) begin
							state_q <= ser_e1_q ? S_EXPRD : S_POW;
						end else begin
							k_q     <= k_q + 5'd1;
							state_q <= S_SMUL;
						end
					end
				end
				S_EXPRD: state_q <= S_EXPX;
				S_EXPX: begin
					if (nbig >= XW'(32)) begin
						ex_q    <= '0;
						state_q <= S_EXPST;
					end else begin
						n_q      <= nbig[4:0];
						y_q      <= {1'b0, xu[7:0], 22'b0};
						term_q   <= Q30_ONE;
						sum_q    <= 34'(Q30_ONE);
						k_q      <= 5'd1;
						ser_e1_q <= 1'b0;
						state_q  <= S_SMUL;
					end
				end
				S_POW: begin
					if (n_q == '0) begin
						ex_q    <= r_q[30:6];
						state_q <= S_EXPST;
					end else begin
						state_q <= S_POWW;
					end
				end
				S_POWW: begin
					n_q     <= n_q - 5'd1;
					state_q <= S_POW;
				end
				S_EXPST: begin
					exp_sum_q <= exp_sum_q + {7'b0, ex_q};
					if (j_end) begin
						j_q     <= '0;
						state_q <= S_PRD;
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= S_EXPRD;
					end
				end
				S_PRD:   state_q <= S_PDIV0;
				S_PDIV0: state_q <= S_PDIV;
				S_PDIV: begin
					if (div_done) begin
						if (sub_lab) plab_q <= div_q[24:0];
						if (j_end) begin
							state_q <= S_LOGI;
						end else begin
							j_q     <= j_q + IW'(1);
							state_q <= S_PRD;
						end
					end
				end
				S_LOGI: begin
					m_q     <= lead;
					z_q     <= {7'b0, pl} << (5'd30 - lead);
					frac_q  <= '0;
					li_q    <= '0;
					state_q <= S_LMUL;
				end
				S_LMUL: state_q <= S_LMULW;
				S_LMULW: begin
					if (zz[31]) begin
						z_q    <= zz >> 1;
						frac_q <= {frac_q[18:0], 1'b1};
					end else begin
						z_q    <= zz;
						frac_q <= {frac_q[18:0], 1'b0};
					end
					li_q    <= li_q + 5'd1;
					state_q <= (li_q == 5'd19) ? S_LN : S_LMUL;
				end
				S_LN: state_q <= S_LNW;
				S_LNW: begin
					loss_sum_q <= loss_sum_q + {27'b0, mul_p_q[54:34]};
					j_q        <= '0;
					state_q    <= grad_enable_q ? S_GRD : S_ROWEND;
				end
				S_GRD:  state_q <= S_GMUL;
				S_GMUL: state_q <= S_GMULW;
				S_GMULW: begin
					gneg_q  <= mul_p_q[65];
					state_q <= S_GDIV;
				end
				S_GDIV: begin
					if (div_done) begin
						valid       <= 1'b1;
						kind        <= KIND_GRAD;
						value       <= gsat;
						class_index <= 4'(j_q);
						last        <= j_end && !emit_loss_q;
						if (j_end) begin
							state_q <= S_ROWEND;
						end else begin
							j_q     <= j_q + IW'(1);
							state_q <= S_GRD;
						end
					end
				end
				S_ROWEND: begin
					row_count_q <= emit_loss_q ? 16'd0 : row_count_q + 16'd1;
					state_q     <= emit_loss_q ? S_LDIV : S_IDLE;
				end
				S_LDIV: begin
					if (div_done) begin
						valid       <= 1'b1;
						kind        <= KIND_LOSS;
						value       <= lsat;
						class_index <= '0;
						last        <= 1'b1;
						loss_sum_q  <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	function automatic logic [30:0] sum_q_next_clamp(input logic signed [33:0] s,
	                                                input logic odd,
	                                                input logic [30:0] t);
		logic signed [33:0] nx;
		nx = odd ? s - 34'(t) : s + 34'(t);
		return nx[33] ? 31'd0 : nx[30:0];
	endfunction

	// series result and power loop share the clamped accumulator / product
	always_ff @(posedge clk) begin
		if (state_q == S_SDIV && div_done && k_q == 5'd16) begin
			if (ser_e1_q) e1_q <= 31'(sum_q_next_clamp(sum_q, k_q[0], div_q[30:0]));
			else          r_q  <= 31'(sum_q_next_clamp(sum_q, k_q[0], div_q[30:0]));
		end else if (state_q == S_POWW) begin
			r_q <= mul_p_q[60:30];
		end
	end

	// assertions
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("sequencer state not one-hot");
	a_more: assert property (@(posedge clk) disable iff (!arst_n) valid && !last |=> busy)
		else $error("sequence ended before last beat");
	a_loss_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == KIND_LOSS |-> last)
		else $error("loss beat not marked last");
	a_from_busy: assert property (@(posedge clk) disable iff (!arst_n) valid |-> $past(busy))
		else $error("beat issued outside a row sequence");
endmodule
